[rtl/softmax_top1_classifier_gate_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the classifier gate RTL
// Implication checks with a common clock and synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_TOP1_CLASSIFIER_GATE_ASSERT_SVH
`define SOFTMAX_TOP1_CLASSIFIER_GATE_ASSERT_SVH

// Same-cycle implication.
`define SMXGATE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smxgate: same-cycle check failed");

// Next-cycle implication.
`define SMXGATE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smxgate: next-cycle check failed");

`endif

[rtl/smxgate_pkg.sv]
// ----------------------------------------------------------------------------
// smxgate_pkg
// Shared widths, stage counts, codes, exp table and transport types.
// ----------------------------------------------------------------------------
`default_nettype none

package smxgate_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int IDX_W       = 3;
  localparam int LOGIT_W     = 16;
  localparam int MARGIN_W    = 16;
  localparam int PROB_W      = 16;

  // result status codes
  typedef enum logic [1:0] {
    ST_EMIT   = 2'd0,
    ST_WEAK   = 2'd1,
    ST_MARGIN = 2'd2,
    ST_PROB   = 2'd3
  } status_t;

  // register map, word index = paddr[3:2]
  localparam logic [1:0] REG_LOGIT_FLOOR = 2'd0;
  localparam logic [1:0] REG_GAP_FLOOR   = 2'd1;
  localparam logic [1:0] REG_PROB_THRESH = 2'd2;

  // exp datapath
  localparam int X_W        = 16;
  localparam int Y_W        = 17;
  localparam int PROD_W     = X_W + Y_W;
  localparam int TERM_W     = 17;
  localparam int SUM_W      = TERM_W + $clog2(NUM_CLASSES);
  localparam int EXP_CUTOFF = 17;
  localparam int EXP_ONE    = 65536;
  localparam logic [Y_W-1:0]    LOG2E_Q16 = Y_W'(94548);
  localparam logic [PROD_W-1:0] ROUND_Q16 = PROD_W'(32768);

  // reciprocal divider
  localparam int NUM_W      = 33;
  localparam int QUO_W      = 17;
  localparam int REM_W      = SUM_W + 1;
  localparam int DIV_SPS    = 2;
  localparam int DIV_STAGES = (QUO_W + DIV_SPS - 1) / DIV_SPS;
  localparam int PROB_MAX   = 65535;

  // pipeline depths
  localparam int RANK_STG = NUM_CLASSES - 1;
  localparam int EXP_STG  = 4;
  localparam int LATENCY  = RANK_STG + EXP_STG + DIV_STAGES + 1;

  typedef logic [LOGIT_W-1:0] logit_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [LOGIT_W-1:0] top1;
    logic [LOGIT_W-1:0] top2;
  } rank_t;

  typedef struct packed {
    logic [IDX_W-1:0]    class_index;
    logic [LOGIT_W-1:0]  max_logit;
    logic [MARGIN_W-1:0] top_gap;
  } meta_t;

  // round(65536 * 2^(-k/16))
  function automatic logic [TERM_W-1:0] exp2_frac(input logic [3:0] k);
    logic [TERM_W-1:0] v;
    unique case (k)
      4'd0:  v = TERM_W'(65536);
      4'd1:  v = TERM_W'(62757);
      4'd2:  v = TERM_W'(60097);
      4'd3:  v = TERM_W'(57549);
      4'd4:  v = TERM_W'(55109);
      4'd5:  v = TERM_W'(52773);
      4'd6:  v = TERM_W'(50535);
      4'd7:  v = TERM_W'(48393);
      4'd8:  v = TERM_W'(46341);
      4'd9:  v = TERM_W'(44376);
      4'd10: v = TERM_W'(42495);
      4'd11: v = TERM_W'(40693);
      4'd12: v = TERM_W'(38968);
      4'd13: v = TERM_W'(37316);
      4'd14: v = TERM_W'(35734);
      4'd15: v = TERM_W'(34219);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/softmax_top1_classifier_gate.sv]
// ----------------------------------------------------------------------------
// softmax_top1_classifier_gate
// Top-1 softmax gate: argmax, margin, winner probability and status gating.
// Pipeline: 4 rank, 4 exp, 9 divider stages, 1 output register.
// Throughput: one transaction per cycle outside reset; the fully pipelined divider sets it.
// The receiver cannot stall, so busy is low whenever reset is released.
// Reset: synchronous, active high; clears all pipeline valid bits and loads
//   the gate registers with their defaults (floors at minimum, threshold 0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "softmax_top1_classifier_gate_assert.svh"

module softmax_top1_classifier_gate (
  input  logic                                   clk,
  input  logic                                   rst,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [smxgate_pkg::LOGIT_W-1:0] logit_0,
  input  logic signed [smxgate_pkg::LOGIT_W-1:0] logit_1,
  input  logic signed [smxgate_pkg::LOGIT_W-1:0] logit_2,
  input  logic signed [smxgate_pkg::LOGIT_W-1:0] logit_3,
  input  logic signed [smxgate_pkg::LOGIT_W-1:0] logit_4,
  // result channel, one-cycle strobe
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [smxgate_pkg::IDX_W-1:0]          class_index,
  output logic [smxgate_pkg::PROB_W-1:0]         top_probability,
  output logic signed [smxgate_pkg::LOGIT_W-1:0] max_logit,
  output logic [smxgate_pkg::MARGIN_W-1:0]       top_gap,
  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import smxgate_pkg::*;

  logic [LOGIT_W-1:0]  logit_floor;
  logic [LOGIT_W-1:0]  gap_floor;
  logic [PROB_W-1:0]   prob_threshold;

  logic                in_valid;
  logit_t              logit_in [NUM_CLASSES];

  logic                rank_valid;
  logit_t              rank_logit [NUM_CLASSES];
  rank_t               rank_info;

  logic                exp_valid;
  logic [SUM_W-1:0]    exp_sum;
  meta_t               exp_meta;

  logic                div_valid;
  logic [QUO_W-1:0]    div_quo;
  meta_t               div_meta;

  logic [PROB_W-1:0]   prob_sat;
  status_t             status_next;
  logic                cfg_wr;

  // --------------------------------------------------------------------------
  // Command side: the pipeline takes a new transaction every cycle; only
  // reset holds it off.
  // --------------------------------------------------------------------------
  assign busy     = rst;
  assign in_valid = start && !busy;

  assign logit_in[0] = logit_0;
  assign logit_in[1] = logit_1;
  assign logit_in[2] = logit_2;
  assign logit_in[3] = logit_3;
  assign logit_in[4] = logit_4;

  // --------------------------------------------------------------------------
  // Datapath: rank scan -> exp terms and sum -> reciprocal divider
  // --------------------------------------------------------------------------
  smxgate_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .logit_in  (logit_in),
    .out_valid (rank_valid),
    .logit_out (rank_logit),
    .rank_out  (rank_info)
  );

  smxgate_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rank_valid),
    .logit_in  (rank_logit),
    .rank_in   (rank_info),
    .out_valid (exp_valid),
    .sum_out   (exp_sum),
    .meta_out  (exp_meta)
  );

  smxgate_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exp_valid),
    .den_in    (exp_sum),
    .meta_in   (exp_meta),
    .out_valid (div_valid),
    .quo_out   (div_quo),
    .meta_out  (div_meta)
  );

  // --------------------------------------------------------------------------
  // Gating. The winner alone gives a sum of 1.0, so the quotient can reach
  // exactly 1.0 and must be clipped into Q0.16. Gates are tried in order:
  // weak maximum, small margin, low probability. Dropped transactions still
  // carry all computed fields.
  // --------------------------------------------------------------------------
  always_comb begin
    if (div_quo > QUO_W'(PROB_MAX)) begin
      prob_sat = PROB_W'(PROB_MAX);
    end else begin
      prob_sat = div_quo[PROB_W-1:0];
    end

    if ($signed(div_meta.max_logit) < $signed(logit_floor)) begin
      status_next = ST_WEAK;
    end else if ($signed({1'b0, div_meta.top_gap})
                 < $signed({gap_floor[LOGIT_W-1], gap_floor})) begin
      // margin is unsigned, the floor signed: compare one bit wider
      status_next = ST_MARGIN;
    end else if (prob_sat < prob_threshold) begin
      status_next = ST_PROB;
    end else begin
      status_next = ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    status          <= status_next;
    class_index     <= div_meta.class_index;
    top_probability <= prob_sat;
    max_logit       <= div_meta.max_logit;
    top_gap         <= div_meta.top_gap;
  end

  // --------------------------------------------------------------------------
  // Register port: zero wait states, writes to unmapped words are dropped
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      logit_floor    <= LOGIT_W'(16'h8000);
      gap_floor      <= LOGIT_W'(16'h8000);
      prob_threshold <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOGIT_FLOOR: logit_floor    <= pwdata[LOGIT_W-1:0];
        REG_GAP_FLOOR:   gap_floor      <= pwdata[LOGIT_W-1:0];
        REG_PROB_THRESH: prob_threshold <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOGIT_FLOOR: prdata = {{(32-LOGIT_W){logit_floor[LOGIT_W-1]}}, logit_floor};
      REG_GAP_FLOOR:   prdata = {{(32-LOGIT_W){gap_floor[LOGIT_W-1]}}, gap_floor};
      REG_PROB_THRESH: prdata = {{(32-PROB_W){1'b0}}, prob_threshold};
      default:         prdata = '0;
    endcase
  end

  `SMXGATE_ASSERT_IMP(a_latency, clk, rst, done, $past(start && !busy, LATENCY))
  `SMXGATE_ASSERT_IMP(a_index_range, clk, rst, done, class_index < IDX_W'(NUM_CLASSES))

endmodule

`default_nettype wire

[rtl/smxgate_rank.sv]
// ----------------------------------------------------------------------------
// smxgate_rank
// Scan pipeline: top-1 (first index on ties) and top-2 logit, one class a stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "softmax_top1_classifier_gate_assert.svh"

module smxgate_rank (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  smxgate_pkg::logit_t logit_in  [smxgate_pkg::NUM_CLASSES],
  output logic                out_valid,
  output smxgate_pkg::logit_t logit_out [smxgate_pkg::NUM_CLASSES],
  output smxgate_pkg::rank_t  rank_out
);
  import smxgate_pkg::*;

  logic   vld     [RANK_STG];
  logit_t lg      [RANK_STG][NUM_CLASSES];
  rank_t  rk      [RANK_STG];
  rank_t  rk_next [RANK_STG];

  always_comb begin
    // first stage pairs classes 0 and 1; strict compare keeps the lower index
    if ($signed(logit_in[1]) > $signed(logit_in[0])) begin
      rk_next[0].idx  = IDX_W'(1);
      rk_next[0].top1 = logit_in[1];
      rk_next[0].top2 = logit_in[0];
    end else begin
      rk_next[0].idx  = '0;
      rk_next[0].top1 = logit_in[0];
      rk_next[0].top2 = logit_in[1];
    end
    for (int s = 1; s < RANK_STG; s++) begin
      rk_next[s] = rk[s-1];
      if ($signed(lg[s-1][s+1]) > $signed(rk[s-1].top1)) begin
        rk_next[s].idx  = IDX_W'(s + 1);
        rk_next[s].top1 = lg[s-1][s+1];
        rk_next[s].top2 = rk[s-1].top1;
      end else if ($signed(lg[s-1][s+1]) > $signed(rk[s-1].top2)) begin
        rk_next[s].top2 = lg[s-1][s+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < RANK_STG; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int s = 1; s < RANK_STG; s++) vld[s] <= vld[s-1];
    end
    lg[0] <= logit_in;
    for (int s = 1; s < RANK_STG; s++) lg[s] <= lg[s-1];
    for (int s = 0; s < RANK_STG; s++) rk[s] <= rk_next[s];
  end

  assign out_valid = vld[RANK_STG-1];
  assign logit_out = lg[RANK_STG-1];
  assign rank_out  = rk[RANK_STG-1];

  `SMXGATE_ASSERT_IMP(a_rank_order, clk, rst, out_valid, $signed(rank_out.top1) >= $signed(rank_out.top2))

endmodule

`default_nettype wire

[rtl/smxgate_exp.sv]
// ----------------------------------------------------------------------------
// smxgate_exp
// Distance to max, log2(e) scaling, table-and-shift exp, term sum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "softmax_top1_classifier_gate_assert.svh"

module smxgate_exp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  smxgate_pkg::logit_t            logit_in [smxgate_pkg::NUM_CLASSES],
  input  smxgate_pkg::rank_t             rank_in,
  output logic                           out_valid,
  output logic [smxgate_pkg::SUM_W-1:0]  sum_out,
  output smxgate_pkg::meta_t             meta_out
);
  import smxgate_pkg::*;

  logic                vld    [EXP_STG];
  meta_t               meta_q [EXP_STG];

  logic [LOGIT_W:0]    diff   [NUM_CLASSES];
  logic [LOGIT_W:0]    mdiff;
  logic [X_W-1:0]      x      [NUM_CLASSES];
  logic [PROD_W-1:0]   prod   [NUM_CLASSES];
  logic [Y_W-1:0]      y      [NUM_CLASSES];
  logic [TERM_W-1:0]   term_next [NUM_CLASSES];
  logic [TERM_W-1:0]   term   [NUM_CLASSES];
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    sum;

  always_comb begin
    // distances are never negative: top1 is the maximum
    for (int i = 0; i < NUM_CLASSES; i++) begin
      diff[i] = {rank_in.top1[LOGIT_W-1], rank_in.top1}
              - {logit_in[i][LOGIT_W-1], logit_in[i]};
    end
    mdiff = {rank_in.top1[LOGIT_W-1], rank_in.top1}
          - {rank_in.top2[LOGIT_W-1], rank_in.top2};

    for (int i = 0; i < NUM_CLASSES; i++) begin
      prod[i] = PROD_W'(x[i]) * PROD_W'(LOG2E_Q16) + ROUND_Q16;
    end

    // y = integer part n (bits 16:8), fraction index k (bits 7:4)
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (y[i][Y_W-1:8] >= (Y_W-8)'(EXP_CUTOFF)) begin
        term_next[i] = '0;
      end else begin
        term_next[i] = exp2_frac(y[i][7:4]) >> y[i][12:8];
      end
    end

    acc = '0;
    for (int i = 0; i < NUM_CLASSES; i++) acc = acc + SUM_W'(term[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < EXP_STG; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int s = 1; s < EXP_STG; s++) vld[s] <= vld[s-1];
    end
    meta_q[0].class_index <= rank_in.idx;
    meta_q[0].max_logit   <= rank_in.top1;
    meta_q[0].top_gap     <= mdiff[MARGIN_W-1:0];
    for (int s = 1; s < EXP_STG; s++) meta_q[s] <= meta_q[s-1];
    for (int i = 0; i < NUM_CLASSES; i++) begin
      x[i]    <= diff[i][X_W-1:0];
      y[i]    <= prod[i][PROD_W-1:16];
      term[i] <= term_next[i];
    end
    sum <= acc;
  end

  assign out_valid = vld[EXP_STG-1];
  assign sum_out   = sum;
  assign meta_out  = meta_q[EXP_STG-1];

  `SMXGATE_ASSERT_NXT(a_winner_dist, clk, rst, in_valid, x[meta_q[0].class_index] == '0)
  `SMXGATE_ASSERT_IMP(a_sum_floor, clk, rst, out_valid, sum_out >= SUM_W'(EXP_ONE))

endmodule

`default_nettype wire

[rtl/smxgate_div.sv]
// ----------------------------------------------------------------------------
// smxgate_div
// Pipelined restoring divider: (2^32 + sum/2) / sum, two quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "softmax_top1_classifier_gate_assert.svh"

module smxgate_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [smxgate_pkg::SUM_W-1:0]  den_in,
  input  smxgate_pkg::meta_t             meta_in,
  output logic                           out_valid,
  output logic [smxgate_pkg::QUO_W-1:0]  quo_out,
  output smxgate_pkg::meta_t             meta_out
);
  import smxgate_pkg::*;

  logic [NUM_W-1:0] num_in;

  logic             vld      [DIV_STAGES];
  logic [REM_W-1:0] rem      [DIV_STAGES];
  logic [QUO_W-1:0] quo      [DIV_STAGES];
  logic [QUO_W-1:0] nlo      [DIV_STAGES];
  logic [SUM_W-1:0] den      [DIV_STAGES];
  meta_t            meta_q   [DIV_STAGES];
  logic [REM_W-1:0] rem_next [DIV_STAGES];
  logic [QUO_W-1:0] quo_next [DIV_STAGES];

  // rounded reciprocal numerator; sum/2 < 2^32 so the add is a concatenation
  assign num_in = {1'b1, (NUM_W-1)'(den_in >> 1)};

  always_comb begin
    logic [REM_W-1:0] r;
    logic [QUO_W-1:0] q;
    logic [QUO_W-1:0] nm;
    logic [SUM_W-1:0] dd;
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        // quotient < 2^17, so the top bits start below the divisor
        r  = REM_W'(num_in[NUM_W-1:QUO_W]);
        q  = '0;
        nm = num_in[QUO_W-1:0];
        dd = den_in;
      end else begin
        r  = rem[j-1];
        q  = quo[j-1];
        nm = nlo[j-1];
        dd = den[j-1];
      end
      for (int t = j * DIV_SPS; t < (j + 1) * DIV_SPS && t < QUO_W; t++) begin
        r = {r[REM_W-2:0], nm[QUO_W-1-t]};
        if (r >= REM_W'(dd)) begin
          r = r - REM_W'(dd);
          q[QUO_W-1-t] = 1'b1;
        end
      end
      rem_next[j] = r;
      quo_next[j] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_STAGES; j++) vld[j] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int j = 1; j < DIV_STAGES; j++) vld[j] <= vld[j-1];
    end
    nlo[0]    <= num_in[QUO_W-1:0];
    den[0]    <= den_in;
    meta_q[0] <= meta_in;
    for (int j = 1; j < DIV_STAGES; j++) begin
      nlo[j]    <= nlo[j-1];
      den[j]    <= den[j-1];
      meta_q[j] <= meta_q[j-1];
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      rem[j] <= rem_next[j];
      quo[j] <= quo_next[j];
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quo_out   = quo[DIV_STAGES-1];
  assign meta_out  = meta_q[DIV_STAGES-1];

  `SMXGATE_ASSERT_IMP(a_quo_bound, clk, rst, out_valid, quo_out <= QUO_W'(EXP_ONE))

endmodule

`default_nettype wire
